@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of the merge core.
// Stand-alone header; the includer supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property, sampled on the rising edge.
`define KWM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("merge core port check failed");

// Antecedent now, consequent on the next edge.
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge core port check failed");

`endif

@@ rtl/core/kwm_pkg.sv @@
// Shared types, sizes and helpers of the k-way merge core.
// No dependencies; every other file of the core but the assertion header refers to it by scope.
package kwm_pkg;

  localparam int SOURCES  = 16;
  localparam int IDX_W    = $clog2(SOURCES);
  localparam int CNT_W    = $clog2(SOURCES + 1);
  localparam int LEAVES   = 1 << IDX_W;

  localparam int SRC_W    = 4;
  localparam int VAL_W    = 32;
  localparam int CFG_W    = 5;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // register index as decoded from paddr[2]
  localparam logic REG_SOURCES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] SIU_RESET = 5'd1;

  typedef struct packed {
    logic [SRC_W-1:0]        source_index;
    logic signed [VAL_W-1:0] head_value;
    logic                    stream_ended;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] merged_value;
    logic [SRC_W-1:0]        refill_source;
    logic                    merge_done;
  } result_t;

  // request after classification in the front part
  typedef struct packed {
    logic  in_use;
    item_t item;
  } ent_t;

  // clamp the programmed count to 1 .. SOURCES
  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] siu);
    int unsigned v;
    v = 32'(siu);
    if (v == 0) v = 1;
    if (v > 32'(SOURCES)) v = 32'(SOURCES);
    return CNT_W'(v);
  endfunction

endpackage

@@ rtl/core/kwm_front.sv @@
// Front part of the merge core: accepts requests, tags them in use or not,
// and queues them for the back part. Depends on kwm_pkg.
module kwm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  kwm_pkg::item_t             item,
  input  logic [kwm_pkg::CNT_W-1:0]  count,
  output logic                       ent_valid,
  output kwm_pkg::ent_t              ent,
  input  logic                       ent_take
);

  kwm_pkg::ent_t                  q [kwm_pkg::IQ_DEPTH];
  logic [kwm_pkg::IQ_PTR_W-1:0]   wr_ptr;
  logic [kwm_pkg::IQ_PTR_W-1:0]   rd_ptr;
  logic [kwm_pkg::IQ_CNT_W-1:0]   cnt;
  logic                           accept;
  kwm_pkg::ent_t                  classed;

  assign full      = (cnt == kwm_pkg::IQ_CNT_W'(kwm_pkg::IQ_DEPTH));
  assign accept    = push && !full;
  assign ent_valid = (cnt != '0);
  assign ent       = q[rd_ptr];

  always_comb begin
    classed.item   = item;
    classed.in_use = (32'(item.source_index) < 32'(count));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= classed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 1'b1;
      if (ent_take) rd_ptr <= rd_ptr + 1'b1;
      case ({accept, ent_take})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ rtl/core/kwm_back.sv @@
// Back part of the merge core: head store, flags and the minimum tree.
// Checks the state left by one request while it applies the next. Depends on kwm_pkg.
module kwm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [kwm_pkg::CNT_W-1:0]  count,
  input  logic                       ent_valid,
  input  kwm_pkg::ent_t              ent,
  output logic                       ent_take,
  input  logic                       res_room,
  output logic                       res_push,
  output kwm_pkg::result_t           res
);

  localparam int NODES = 2 * kwm_pkg::LEAVES - 1;

  logic signed [kwm_pkg::VAL_W-1:0] head [kwm_pkg::SOURCES];
  logic [kwm_pkg::SOURCES-1:0]      present;
  logic [kwm_pkg::SOURCES-1:0]      finished;
  logic [kwm_pkg::SOURCES-1:0]      present_next;
  logic [kwm_pkg::SOURCES-1:0]      finished_next;
  logic [kwm_pkg::SOURCES-1:0]      head_we;
  logic [kwm_pkg::SOURCES-1:0]      use_mask;
  logic                             pend;

  logic signed [kwm_pkg::VAL_W-1:0] nv [NODES];
  logic [kwm_pkg::IDX_W-1:0]        ni [NODES];
  logic [NODES-1:0]                 nok;

  logic all_ready;
  logic all_fin;
  logic check_go;
  logic pick;
  logic done;

  always_comb begin
    for (int i = 0; i < kwm_pkg::SOURCES; i++) begin
      use_mask[i] = (32'(i) < 32'(count));
    end
  end

  // tournament over all heads; left child holds lower indices and wins ties
  always_comb begin
    for (int j = 0; j < kwm_pkg::LEAVES; j++) begin
      ni[kwm_pkg::LEAVES-1+j] = kwm_pkg::IDX_W'(j);
      if (j < kwm_pkg::SOURCES) begin
        nv[kwm_pkg::LEAVES-1+j]  = head[j];
        nok[kwm_pkg::LEAVES-1+j] = present[j] && use_mask[j];
      end else begin
        nv[kwm_pkg::LEAVES-1+j]  = '0;
        nok[kwm_pkg::LEAVES-1+j] = 1'b0;
      end
    end
    for (int k = kwm_pkg::LEAVES - 2; k >= 0; k--) begin
      if (nok[2*k+2] && (!nok[2*k+1] || (nv[2*k+2] < nv[2*k+1]))) begin
        nv[k] = nv[2*k+2];
        ni[k] = ni[2*k+2];
      end else begin
        nv[k] = nv[2*k+1];
        ni[k] = ni[2*k+1];
      end
      nok[k] = nok[2*k+1] || nok[2*k+2];
    end
  end

  assign all_ready = &(~use_mask | finished | present);
  assign all_fin   = &(~use_mask | finished);
  assign check_go  = pend && res_room;
  assign done      = all_ready && all_fin;
  assign pick      = all_ready && !all_fin && nok[0];
  assign res_push  = check_go && (pick || done);
  assign ent_take  = ent_valid && (!pend || check_go);

  always_comb begin
    res.merged_value  = done ? '0 : nv[0];
    res.refill_source = done ? '0 : kwm_pkg::SRC_W'(ni[0]);
    res.merge_done    = done;
  end

  // clear from the check first, then apply the incoming request on top
  always_comb begin
    present_next  = present;
    finished_next = finished;
    head_we       = '0;
    if (check_go && done) begin
      present_next  = '0;
      finished_next = '0;
    end else if (check_go && pick) begin
      present_next[ni[0]] = 1'b0;
    end
    for (int i = 0; i < kwm_pkg::SOURCES; i++) begin
      if (ent_take && ent.in_use && !finished_next[i] &&
          (32'(ent.item.source_index) == 32'(i))) begin
        if (ent.item.stream_ended) begin
          finished_next[i] = 1'b1;
          present_next[i]  = 1'b0;
        end else begin
          present_next[i]  = 1'b1;
          head_we[i]       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < kwm_pkg::SOURCES; i++) begin
      if (head_we[i]) head[i] <= ent.item.head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      finished <= '0;
      pend     <= 1'b0;
    end else begin
      present  <= present_next;
      finished <= finished_next;
      if (ent_take) begin
        pend <= 1'b1;
      end else if (check_go) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/kwm_result_q.sv @@
// Result queue of the merge core: holds finished results until popped.
// Depends on kwm_pkg.
module kwm_result_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  kwm_pkg::result_t  wr_data,
  output logic              room,
  output logic              empty,
  input  logic              pop,
  output kwm_pkg::result_t  result
);

  kwm_pkg::result_t               q [kwm_pkg::RQ_DEPTH];
  logic [kwm_pkg::RQ_PTR_W-1:0]   wr_ptr;
  logic [kwm_pkg::RQ_PTR_W-1:0]   rd_ptr;
  logic [kwm_pkg::RQ_CNT_W-1:0]   cnt;
  logic                           rd;

  assign room   = (cnt != kwm_pkg::RQ_CNT_W'(kwm_pkg::RQ_DEPTH));
  assign empty  = (cnt == '0);
  assign rd     = pop && !empty;
  assign result = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ rtl/core/k_way_merge_min_select_core.sv @@
// Path: request queue, head store and flags, result queue. Throughput: one request
//   per cycle while the result queue has room; the check of one request overlaps
//   the apply of the next, paced by the combinational minimum tree over all heads.
// Reset (rst, synchronous, high): empty both queues, clear all present and
//   finished flags, set sources_in_use to 1; head values stay as they are.
module k_way_merge_min_select_core (
  input  logic                          clk,
  input  logic                          rst,
  // request side
  input  logic                          push,
  output logic                          full,
  input  kwm_pkg::item_t                item,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output kwm_pkg::result_t              result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwm_pkg::ADDR_W-1:0]    paddr,
  input  logic [kwm_pkg::DATA_W-1:0]    pwdata,
  output logic [kwm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [kwm_pkg::CFG_W-1:0] sources_in_use;
  logic [kwm_pkg::CNT_W-1:0] count;
  logic                      cfg_wr;

  logic                      ent_valid;
  kwm_pkg::ent_t             ent;
  logic                      ent_take;
  logic                      res_room;
  logic                      res_push;
  kwm_pkg::result_t          res;

  // Register decode: only paddr[2] selects; the low byte bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sources_in_use <= kwm_pkg::SIU_RESET;
    end else if (cfg_wr && (paddr[2] == kwm_pkg::REG_SOURCES_IN_USE)) begin
      sources_in_use <= pwdata[kwm_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == kwm_pkg::REG_SOURCES_IN_USE) begin
      prdata = kwm_pkg::DATA_W'(sources_in_use);
    end
  end

  // Zero acts as one, anything past the source count clamps to it.
  assign count = kwm_pkg::eff_count(sources_in_use);

  // Front: take requests, tag whether the source index is in use, queue them.
  kwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .count     (count),
    .ent_valid (ent_valid),
    .ent       (ent),
    .ent_take  (ent_take)
  );

  // Back: apply each request to the heads and flags, then pick the minimum once
  // every source in use holds a head or has ended, or mark the merge done once all
  // have ended. Stall only when the result queue has no room for a pending check.
  kwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .count     (count),
    .ent_valid (ent_valid),
    .ent       (ent),
    .ent_take  (ent_take),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res)
  );

  // Results wait here so the back part keeps going while the consumer stalls.
  kwm_result_q u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res),
    .room    (res_room),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ rtl/core/kwm_port_checker.sv @@
// Port-level checks of the merge core, bound to the top level.
// Depends on kwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kwm_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input kwm_pkg::result_t  result
);

  // out of reset the result queue is empty and the request queue not full
  `KWM_ASSERT(a_reset_clear, clk, rst, $past(rst) |-> (empty && !full))

  // the done marker carries zero value and zero source
  `KWM_ASSERT(a_done_zero, clk, rst, (!empty && result.merge_done) |-> ((result.merged_value == 0) && (result.refill_source == 0)))

  // the request queue fills only through an accepted request
  `KWM_ASSERT(a_full_by_push, clk, rst, $rose(full) |-> $past(push))

  // a waiting result holds until popped
  `KWM_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(result))

endmodule

bind k_way_merge_min_select_core kwm_port_checker u_port_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ test/testbench.sv @@
// Self-checking bench for k_way_merge_min_select_core: merges of random ascending
// streams against a cycle-free prediction of the minimum selection.
// Depends on kwm_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import kwm_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic [ADDR_W-1:0] SIU_ADDR = ADDR_W'(4 * int'(REG_SOURCES_IN_USE));
  // margin for the block's own path, with a full request queue on top
  localparam int SETTLE_CYCLES = 12;

  // Predicts the merge results and checks each one the block delivers.
  class merge_scoreboard;
    logic signed [VAL_W-1:0] heads[SOURCES];
    bit present[SOURCES];
    bit finished[SOURCES];
    logic [CFG_W-1:0] count_reg;
    result_t awaited[$];
    int mismatches;
    int merges_done;
    int requests_seen;
    int results_seen;

    function new();
      foreach (heads[i]) begin
        heads[i] = '0;
        present[i] = 0;
        finished[i] = 0;
      end
      count_reg = SIU_RESET;
      mismatches = 0;
      merges_done = 0;
      requests_seen = 0;
      results_seen = 0;
    endfunction

    function int active_sources();
      int n;
      n = int'(count_reg);
      if (n == 0) n = 1;
      if (n > SOURCES) n = SOURCES;
      return n;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Apply one accepted request, then queue the result it causes, if any.
    function void note_request(item_t it);
      int n;
      int src;
      int best;
      bit all_ready;
      bit all_finished;
      result_t r;
      n = active_sources();
      src = int'(it.source_index);
      all_ready = 1;
      all_finished = 1;
      best = -1;
      requests_seen++;
      if (src < n && !finished[src]) begin
        if (it.stream_ended) begin
          finished[src] = 1;
          present[src] = 0;
        end else begin
          heads[src] = it.head_value;
          present[src] = 1;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (!finished[i]) all_finished = 0;
        if (!finished[i] && !present[i]) all_ready = 0;
      end
      if (!all_ready) return;
      if (all_finished) begin
        foreach (present[i]) begin
          present[i] = 0;
          finished[i] = 0;
        end
        r.merged_value = '0;
        r.refill_source = '0;
        r.merge_done = 1'b1;
        awaited.push_back(r);
        merges_done++;
        return;
      end
      // strict less-than keeps the lowest index on a tie
      for (int i = 0; i < n; i++) begin
        if (present[i] && (best < 0 || heads[i] < heads[best])) best = i;
      end
      if (best < 0) return;
      present[best] = 0;
      r.merged_value = heads[best];
      r.refill_source = SRC_W'(best);
      r.merge_done = 1'b0;
      awaited.push_back(r);
    endfunction

    task check_result(result_t got);
      result_t exp;
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d/%0d with nothing awaited",
                                  got.merged_value, got.refill_source, got.merge_done));
      end else begin
        exp = awaited.pop_front();
        if (got.merged_value !== exp.merged_value)
          report_mismatch($sformatf("merged_value %0d, expected %0d",
                                    got.merged_value, exp.merged_value));
        if (got.refill_source !== exp.refill_source)
          report_mismatch($sformatf("refill_source %0d, expected %0d",
                                    got.refill_source, exp.refill_source));
        if (got.merge_done !== exp.merge_done)
          report_mismatch($sformatf("merge_done %0b, expected %0b",
                                    got.merge_done, exp.merge_done));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  item_t item;
  logic empty;
  logic pop;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  merge_scoreboard sb = new();

  // idling switches for the sender and the receiver
  bit gaps_on;
  bit stalls_on;

  // per-stream generator state for well-formed merges
  longint stream_last[SOURCES];
  int stream_left[SOURCES];
  int merges_seen;

  k_way_merge_min_select_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Sample both handshakes at the rising edge: check the delivered result
  // first, then fold the accepted request into the prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_result(result);
      if (push && !full) sb.note_request(item);
    end
  end

  // Receiver: pop freely, with stall bursts while stalls are enabled.
  initial begin
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still awaited", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // Call at a falling edge; hold the request until accepted, return at the
  // next falling edge with push still high.
  task push_request(item_t it);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Call at a falling edge; drop push and idle for the span that n sets.
  task idle_for(int n);
    push <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Pause the sender until every awaited result is back and the block has
  // had time to retire any request that produced nothing.
  task drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write sources_in_use, then read it back. Call at a falling edge while idle.
  task program_count(logic [CFG_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIU_ADDR;
    pwdata <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.count_reg = v;
    @(negedge clk);
    // move straight from the write access into the read setup
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== v)
      sb.report_mismatch($sformatf("sources_in_use reads %0d, wrote %0d",
                                   prdata[CFG_W-1:0], v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function item_t make_item(int src, logic signed [VAL_W-1:0] v, bit ended);
    item_t it;
    it.source_index = SRC_W'(src);
    it.head_value = v;
    it.stream_ended = ended;
    return it;
  endfunction

  // Start a fresh set of ascending streams: mixed start points and lengths.
  function void restart_streams();
    for (int i = 0; i < SOURCES; i++) begin
      case ($urandom_range(0, 3))
        0: stream_last[i] = longint'(VAL_MIN);
        1: stream_last[i] = longint'($signed($urandom));
        2: stream_last[i] = longint'(VAL_MAX) - $urandom_range(0, 20);
        default: stream_last[i] = $urandom_range(0, 50);
      endcase
      stream_left[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(0, 5);
    end
    merges_seen = sb.merges_done;
  endfunction

  // Mostly refill a source that the block waits on with the next number of
  // its stream (or its end mark); sometimes send noise.
  function item_t next_request();
    int needy[$];
    int n;
    int src;
    longint nxt;
    if (sb.merges_done != merges_seen) restart_streams();
    n = sb.active_sources();
    for (int i = 0; i < n; i++)
      if (!sb.present[i] && !sb.finished[i]) needy.push_back(i);
    if (needy.size() == 0 && n < SOURCES)
      // a count shrink left the check pending; an unused index triggers it
      return make_item($urandom_range(n, SOURCES - 1), $signed($urandom), 1'b0);
    if (needy.size() == 0 || $urandom_range(0, 99) < 15)
      return make_item($urandom_range(0, SOURCES - 1), $signed($urandom),
                       $urandom_range(0, 9) == 0);
    src = needy[$urandom_range(0, needy.size() - 1)];
    if (stream_left[src] == 0) return make_item(src, $signed($urandom), 1'b1);
    case ($urandom_range(0, 3))
      0: nxt = stream_last[src];
      1: nxt = stream_last[src] + $urandom_range(1, 9);
      2: nxt = stream_last[src] + $urandom_range(1, 100000);
      default: nxt = stream_last[src] + longint'($urandom);
    endcase
    if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
    stream_last[src] = nxt;
    stream_left[src]--;
    return make_item(src, VAL_W'(nxt), 1'b0);
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_counts[9];
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    pop = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    merges_seen = 0;
    phase_counts = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd17, 5'd0, 5'd1, 5'd0, 5'd8};
    phase_counts[7] = CFG_W'($urandom_range(1, SOURCES));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: three sources, walk every special case once.
    program_count(5'd3);
    push_request(make_item(0, 5, 1'b0));
    push_request(make_item(1, 5, 1'b0));
    push_request(make_item(15, -1, 1'b0));       // index out of use: ignored
    push_request(make_item(0, 7, 1'b0));         // overwrite a present head
    push_request(make_item(2, 5, 1'b0));         // tie at 5: lower index wins
    push_request(make_item(1, VAL_MAX, 1'b0));
    push_request(make_item(2, 1, 1'b1));         // end a source with no head
    push_request(make_item(1, 0, 1'b1));         // end drops a present head
    push_request(make_item(2, 9, 1'b0));         // finished source: ignored
    push_request(make_item(0, VAL_MIN, 1'b0));
    push_request(make_item(0, 0, 1'b1));         // last end: merge done
    push_request(make_item(1, VAL_MAX, 1'b0));
    push_request(make_item(0, VAL_MAX, 1'b0));
    push_request(make_item(2, VAL_MAX, 1'b0));   // largest value still selected
    push_request(make_item(0, 0, 1'b1));
    push_request(make_item(1, 0, 1'b1));
    push_request(make_item(2, 0, 1'b1));
    drain();

    // Directed: a count of zero acts as one source.
    program_count(5'd0);
    push_request(make_item(1, 3, 1'b0));         // beyond the single source
    push_request(make_item(0, VAL_MAX, 1'b0));
    push_request(make_item(0, 0, 1'b1));
    drain();

    // Random phases: each writes a count while idle, then runs well-formed
    // merges with noise mixed in. Alternate phases run without idling, and
    // the last one has none on either side.
    restart_streams();
    for (int p = 0; p < 9; p++) begin
      program_count(phase_counts[p]);
      gaps_on = (p % 2 == 0) && (p != 8);
      stalls_on = gaps_on;
      for (int k = 0; k < 56; k++) begin
        if (gaps_on && $urandom_range(0, 9) == 0) idle_for($urandom_range(1, 17));
        push_request(next_request());
        // hold the sender once mid-phase until the block has caught up
        if (p == 3 && k == 27) drain();
      end
      drain();
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d requests, checked %0d results, %0d merges completed,",
             sb.requests_seen, sb.results_seen, sb.merges_done);
    $display("with source counts from 0 to 31 and random idling on both sides.");
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
